// ===== rtl/core/pxf_pkg.sv =====
// Package for the escape-framed pixel stream receiver.
// Holds shared constants, event codes and the result struct; no dependencies.
package pxf_pkg;

	localparam int unsigned PXF_MAX_PIXELS      = 1024;
	localparam int unsigned PXF_LONGEST_COMMAND = 65;

	localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
	localparam logic [3:0] RUN_MAX     = 4'd15;

	localparam logic [7:0] CMD_ID_SHORT_A = 8'h01;
	localparam logic [7:0] CMD_ID_LONG    = 8'h02;
	localparam logic [7:0] CMD_ID_SHORT_B = 8'h03;

	localparam logic [1:0] EV_PIXEL   = 2'd0;
	localparam logic [1:0] EV_REFRESH = 2'd1;
	localparam logic [1:0] EV_CMD     = 2'd2;
	localparam logic [1:0] EV_REJECT  = 2'd3;

	localparam logic CFG_PIXEL_LIMIT      = 1'b0;
	localparam logic CFG_ESCAPE_THRESHOLD = 1'b1;

	localparam logic [10:0] PIXEL_LIMIT_RESET      = 11'd1024;
	localparam logic [3:0]  ESCAPE_THRESHOLD_RESET = 4'd8;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [9:0] pixel_number;
		logic [7:0] color_first;
		logic [7:0] color_second;
		logic [7:0] color_third;
		logic [7:0] command_code;
		logic [6:0] command_offset;
		logic [7:0] command_data;
		logic       command_last;
	} result_t;

	function automatic logic cmd_known(input logic [7:0] id);
		return (id == CMD_ID_SHORT_A) || (id == CMD_ID_LONG) || (id == CMD_ID_SHORT_B);
	endfunction

endpackage

// ===== rtl/core/pxf_stream_if.sv =====
// Stream interfaces for the receiver: byte input and event output channels.
// Field widths are written out to match pxf_pkg; no dependencies.
interface pxf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface pxf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [9:0] pixel_number;
	logic [7:0] color_first;
	logic [7:0] color_second;
	logic [7:0] color_third;
	logic [7:0] command_code;
	logic [6:0] command_offset;
	logic [7:0] command_data;
	logic       command_last;

	modport source (output valid, output event_kind, output pixel_number,
		output color_first, output color_second, output color_third,
		output command_code, output command_offset, output command_data,
		output command_last, input ready);
	modport sink (input valid, input event_kind, input pixel_number,
		input color_first, input color_second, input color_third,
		input command_code, input command_offset, input command_data,
		input command_last, output ready);
endinterface

// ===== rtl/core/pxf_in_stage.sv =====
// Input register stage: captures one received byte per request.
// Depends on pxf_in_if.
module pxf_in_stage (
	input  logic         clk,
	input  logic         arst_n,
	pxf_in_if.sink       rx,
	input  logic         ready_s1,
	output logic         valid_s1,
	output logic [7:0]   byte_s1
);

	assign rx.ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

// ===== rtl/core/pxf_decode.sv =====
// Frame decoder: mode, grouping and command state plus configuration registers.
// Depends on pxf_pkg; produces at most one result per consumed byte.
module pxf_decode import pxf_pkg::*; #(
	parameter int unsigned MAX_PIXELS      = PXF_MAX_PIXELS,
	parameter int unsigned LONGEST_COMMAND = PXF_LONGEST_COMMAND
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [10:0]   cfg_wdata,
	input  logic          take,
	input  logic [7:0]    byte_s1,
	output logic          res_valid,
	output result_t       res
);

	localparam int CNT_W = (LONGEST_COMMAND > 1) ? $clog2(LONGEST_COMMAND) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LONGEST_COMMAND - 1);

	logic [10:0]      pixel_limit_q;
	logic [3:0]       escape_threshold_q;

	logic             cmd_q, cmd_d;
	logic [1:0]       phase_q, phase_d;
	logic [7:0]       hold0_q, hold0_d;
	logic [7:0]       hold1_q, hold1_d;
	logic [10:0]      np_q, np_d;
	logic [3:0]       run_q, run_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_limit_q      <= PIXEL_LIMIT_RESET;
			escape_threshold_q <= ESCAPE_THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PIXEL_LIMIT:      pixel_limit_q      <= cfg_wdata;
				CFG_ESCAPE_THRESHOLD: escape_threshold_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd_d     = cmd_q;
		phase_d   = phase_q;
		hold0_d   = hold0_q;
		hold1_d   = hold1_q;
		np_d      = np_q;
		run_d     = run_q;
		cnt_d     = cnt_q;
		code_d    = code_q;
		res_valid = 1'b0;
		res       = '0;

		if (!cmd_q) begin
			if (byte_s1 != ESCAPE_BYTE) begin
				run_d = '0;
				if (phase_q == 2'd0) begin
					hold0_d = byte_s1;
					phase_d = 2'd1;
				end else if (phase_q == 2'd1) begin
					hold1_d = byte_s1;
					phase_d = 2'd2;
				end else begin
					phase_d = 2'd0;
					if (np_q < pixel_limit_q && 32'(np_q) < MAX_PIXELS) begin
						res_valid          = 1'b1;
						res.event_kind     = EV_PIXEL;
						res.pixel_number   = np_q[9:0];
						res.color_first    = byte_s1;
						res.color_second   = hold1_q;
						res.color_third    = hold0_q;
						np_d               = np_q + 11'd1;
					end
				end
			end else begin
				phase_d = '0;
				np_d    = '0;
				if (run_q != RUN_MAX) begin
					run_d = run_q + 4'd1;
				end
				if (run_d > escape_threshold_q) begin
					cmd_d = 1'b1;
					cnt_d = '0;
				end
				// first escape of a run asks for a refresh
				if (run_d == 4'd1) begin
					res_valid      = 1'b1;
					res.event_kind = EV_REFRESH;
				end
			end
		end else if (!(cnt_q == '0 && byte_s1 == ESCAPE_BYTE)) begin
			if (cnt_q == '0) begin
				code_d = byte_s1;
			end
			res_valid          = 1'b1;
			res.command_code   = code_d;
			res.command_data   = byte_s1;
			if (!cmd_known(code_d)) begin
				res.event_kind     = EV_REJECT;
				res.command_offset = '0;
				res.command_last   = 1'b1;
			end else begin
				res.event_kind     = EV_CMD;
				res.command_offset = 7'(cnt_q);
				res.command_last   = (code_d != CMD_ID_LONG) || (cnt_q == CNT_LAST);
				cnt_d              = cnt_q + 1'b1;
			end
			if (res.command_last) begin
				cmd_d   = 1'b0;
				phase_d = '0;
				hold0_d = '0;
				hold1_d = '0;
				np_d    = '0;
				run_d   = '0;
				cnt_d   = '0;
				code_d  = '0;
			end
		end

		if (!take) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= 1'b0;
			phase_q <= '0;
			hold0_q <= '0;
			hold1_q <= '0;
			np_q    <= '0;
			run_q   <= '0;
			cnt_q   <= '0;
			code_q  <= '0;
		end else if (take) begin
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			hold0_q <= hold0_d;
			hold1_q <= hold1_d;
			np_q    <= np_d;
			run_q   <= run_d;
			cnt_q   <= cnt_d;
			code_q  <= code_d;
		end
	end

`ifndef ASSERT_OFF
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("byte phase out of range");

	a_cmd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q |-> (phase_q == '0 && np_q == '0))
		else $error("pixel state not cleared in command mode");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < LONGEST_COMMAND) else $error("command count past longest command");

	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_q |-> (cnt_q == '0 && code_q == '0))
		else $error("command state left over in data mode");
`endif

endmodule

// ===== rtl/core/pxf_out_stage.sv =====
// Result register stage: holds one event until the sink takes it.
// Depends on pxf_pkg and pxf_out_if.
module pxf_out_stage import pxf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     res_valid,
	input  result_t  res,
	output logic     ready_s1,
	pxf_out_if.source ev
);

	logic    valid_s2;
	result_t res_s2;

	assign ready_s1 = !valid_s2 || ev.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && res_valid) begin
			res_s2 <= res;
		end
	end

	assign ev.valid          = valid_s2;
	assign ev.event_kind     = res_s2.event_kind;
	assign ev.pixel_number   = res_s2.pixel_number;
	assign ev.color_first    = res_s2.color_first;
	assign ev.color_second   = res_s2.color_second;
	assign ev.color_third    = res_s2.color_third;
	assign ev.command_code   = res_s2.command_code;
	assign ev.command_offset = res_s2.command_offset;
	assign ev.command_data   = res_s2.command_data;
	assign ev.command_last   = res_s2.command_last;

endmodule

// ===== rtl/core/pixel_stream_escape_framer.sv =====
// Escape-framed pixel stream receiver, top level.
// An event reaches event_stream via the input register and the result register.
// Throughput: one byte per cycle; the input register, decoder and result register
// form a two-stage pipeline that stalls only when the result register is held.
// Reset: asynchronous; clears all frame and command state, pipeline valids,
// and loads pixel_limit 1024 and escape_threshold 8.
module pixel_stream_escape_framer import pxf_pkg::*; #(
	parameter int unsigned MAX_PIXELS      = PXF_MAX_PIXELS,
	parameter int unsigned LONGEST_COMMAND = PXF_LONGEST_COMMAND
) (
	input  logic        clk,
	input  logic        arst_n,
	pxf_in_if.sink      rx_stream,
	pxf_out_if.source   event_stream,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_wdata
);

	logic       ready_s1;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid;
	result_t    res;

	pxf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_stream),
		.ready_s1 (ready_s1),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	pxf_decode #(
		.MAX_PIXELS      (MAX_PIXELS),
		.LONGEST_COMMAND (LONGEST_COMMAND)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.take      (valid_s1 && ready_s1),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	pxf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.ready_s1  (ready_s1),
		.ev        (event_stream)
	);

endmodule
